// ===== src/stm_pkg.sv =====
// Shared types and constants for the SAD template matcher.
// No dependencies; used by every other file of the block but stm_checker.
`timescale 1ns / 1ps

package stm_pkg;

    localparam int PIX_W      = 8;
    localparam int FDIM_W     = 9;   // frame size register width
    localparam int TDIM_W     = 6;   // template size register width
    localparam int POS_W      = 9;   // cursor and best position width
    localparam int WIN_W      = 8;   // reported window position width
    localparam int SAD_W      = 18;
    localparam int BEST_SAD_W = 31;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 88;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SAD_W-1:0]      SAD_SAT  = 18'h3ffff;
    localparam logic [BEST_SAD_W-1:0] SAD_NONE = 31'h7fffffff;
    localparam logic [POS_W-1:0]      POS_NONE = 9'h1ff;

    // register indexes on the APB port
    localparam logic [1:0] REG_FRAME_COLS = 2'd0;
    localparam logic [1:0] REG_FRAME_ROWS = 2'd1;
    localparam logic [1:0] REG_TMPL_COLS  = 2'd2;
    localparam logic [1:0] REG_TMPL_ROWS  = 2'd3;

    typedef enum logic [1:0] {
        OP_WR_FRAME = 2'd0,
        OP_WR_TMPL  = 2'd1,
        OP_EVAL     = 2'd2,
        OP_RESTART  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_NONE
    } state_t;

    typedef struct packed {
        logic wr_frame;
        logic wr_tmpl;
        logic restart;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic load_none;
    } ctrl_cmd_t;

    typedef struct packed {
        logic none_left;
        logic scan_last;
        logic pipe_busy;
    } dp_status_t;

endpackage

// ===== src/stm_ctrl.sv =====
// Controller state machine of the SAD template matcher.
// Depends on stm_pkg; drives stm_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module stm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [1:0]             s_op,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output stm_pkg::ctrl_cmd_t     cmd,
    input  stm_pkg::dp_status_t    status
);

    stm_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            accept;
    logic            out_free;
    stm_pkg::op_t    op;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign op       = stm_pkg::op_t'(s_op);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stm_pkg::ST_IDLE: begin
                if (accept && op == stm_pkg::OP_EVAL) begin
                    state_next = status.none_left ? stm_pkg::ST_NONE : stm_pkg::ST_SCAN;
                end
            end
            stm_pkg::ST_SCAN: begin
                if (status.scan_last) state_next = stm_pkg::ST_DRAIN;
            end
            stm_pkg::ST_DRAIN: begin
                if (!status.pipe_busy) state_next = stm_pkg::ST_COMMIT;
            end
            stm_pkg::ST_COMMIT: begin
                if (out_free) state_next = stm_pkg::ST_IDLE;
            end
            stm_pkg::ST_NONE: begin
                if (out_free) state_next = stm_pkg::ST_IDLE;
            end
            default: state_next = stm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            stm_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.wr_frame   = accept && op == stm_pkg::OP_WR_FRAME;
                cmd.wr_tmpl    = accept && op == stm_pkg::OP_WR_TMPL;
                cmd.restart    = accept && op == stm_pkg::OP_RESTART;
                cmd.scan_start = accept && op == stm_pkg::OP_EVAL && !status.none_left;
            end
            stm_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
            stm_pkg::ST_DRAIN:  cmd = '0;
            stm_pkg::ST_COMMIT: cmd.commit    = out_free;
            stm_pkg::ST_NONE:   cmd.load_none = out_free;
            default:            cmd = '0;
        endcase
    end

    // result register: loaded by commit or load_none, emptied by the sink
    always_comb begin
        if (cmd.commit || cmd.load_none) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

// ===== src/stm_datapath.sv =====
// Datapath of the SAD template matcher: pixel memories, read pipeline,
// accumulator, scan cursor, running best and result register. Depends on stm_pkg.
`timescale 1ns / 1ps

module stm_datapath #(
    parameter int MAX_FRAME_W = 256,
    parameter int MAX_FRAME_H = 256,
    parameter int MAX_TMPL_W  = 32,
    parameter int MAX_TMPL_H  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  stm_pkg::ctrl_cmd_t                cmd,
    output stm_pkg::dp_status_t               status,
    input  logic [stm_pkg::FDIM_W-1:0]        frame_cols,
    input  logic [stm_pkg::FDIM_W-1:0]        frame_rows,
    input  logic [stm_pkg::TDIM_W-1:0]        tmpl_cols,
    input  logic [stm_pkg::TDIM_W-1:0]        tmpl_rows,
    input  logic [7:0]                        in_row,
    input  logic [7:0]                        in_col,
    input  logic [stm_pkg::PIX_W-1:0]         in_pixel,
    output logic [stm_pkg::WIN_W-1:0]         win_row,
    output logic [stm_pkg::WIN_W-1:0]         win_col,
    output logic [stm_pkg::SAD_W-1:0]         win_sad,
    output logic [stm_pkg::POS_W-1:0]         best_row,
    output logic [stm_pkg::POS_W-1:0]         best_col,
    output logic [stm_pkg::BEST_SAD_W-1:0]    best_sad,
    output logic                              last,
    output logic                              none_left
);

    localparam int FDEPTH = MAX_FRAME_W * MAX_FRAME_H;
    localparam int TDEPTH = MAX_TMPL_W * MAX_TMPL_H;
    localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
    localparam int TA_W   = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int TK_W   = (MAX_TMPL_H > 1) ? $clog2(MAX_TMPL_H) : 1;
    localparam int TL_W   = (MAX_TMPL_W > 1) ? $clog2(MAX_TMPL_W) : 1;
    localparam int ACC_RAW_W = $clog2(TDEPTH * 255 + 1);
    localparam int ACC_W  = (ACC_RAW_W > stm_pkg::SAD_W) ? ACC_RAW_W : stm_pkg::SAD_W;

    localparam int FD = stm_pkg::FDIM_W;
    localparam int TD = stm_pkg::TDIM_W;
    localparam int PW = stm_pkg::POS_W;

    // size 0 counts as 1, sizes above the maximum count as the maximum
    function automatic logic [FD-1:0] clamp_f(input logic [FD-1:0] v, input int hi);
        logic [FD-1:0] r;
        if (v == '0) r = FD'(1);
        else if (int'(v) > hi) r = FD'(hi);
        else r = v;
        return r;
    endfunction

    function automatic logic [TD-1:0] clamp_t(input logic [TD-1:0] v, input int hi);
        logic [TD-1:0] r;
        if (v == '0) r = TD'(1);
        else if (int'(v) > hi) r = TD'(hi);
        else r = v;
        return r;
    endfunction

    logic [FD-1:0] fc, fr;
    logic [TD-1:0] tc, tr;

    assign fc = clamp_f(frame_cols, MAX_FRAME_W);
    assign fr = clamp_f(frame_rows, MAX_FRAME_H);
    assign tc = clamp_t(tmpl_cols, MAX_TMPL_W);
    assign tr = clamp_t(tmpl_rows, MAX_TMPL_H);

    // memories
    logic [stm_pkg::PIX_W-1:0] frame_mem [FDEPTH];
    logic [stm_pkg::PIX_W-1:0] tmpl_mem  [TDEPTH];

    logic [FA_W-1:0] wr_faddr;
    logic [TA_W-1:0] wr_taddr;
    logic            frame_wr_ok, tmpl_wr_ok;

    assign frame_wr_ok = (32'(in_row) < MAX_FRAME_H) && (32'(in_col) < MAX_FRAME_W);
    assign tmpl_wr_ok  = (32'(in_row) < MAX_TMPL_H) && (32'(in_col) < MAX_TMPL_W);
    assign wr_faddr    = FA_W'(32'(in_row) * MAX_FRAME_W + 32'(in_col));
    assign wr_taddr    = TA_W'(32'(in_row) * MAX_TMPL_W + 32'(in_col));

    // scan cursor, running best
    logic [PW-1:0]                     cur_row_reg, cur_col_reg;
    logic [PW-1:0]                     cur_row_next, cur_col_next;
    logic                              done_reg, done_next;
    logic [PW-1:0]                     best_row_reg, best_col_reg;
    logic [PW-1:0]                     best_row_next, best_col_next;
    logic [stm_pkg::BEST_SAD_W-1:0]    best_sad_reg, best_sad_next;

    // template walk counters
    logic [TK_W-1:0] k_reg, k_next;
    logic [TL_W-1:0] l_reg, l_next;
    logic            l_end, k_end;

    assign l_end = (7'(l_reg) + 7'd1) == 7'(tc);
    assign k_end = (7'(k_reg) + 7'd1) == 7'(tr);

    // read pipeline: position -> address -> memory -> |diff| -> accumulate
    logic                      a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic [PW-1:0]             a_frow_reg, a_fcol_reg;
    logic [TK_W-1:0]           a_k_reg;
    logic [TL_W-1:0]           a_l_reg;
    logic [FA_W-1:0]           b_faddr_reg;
    logic [TA_W-1:0]           b_taddr_reg;
    logic [stm_pkg::PIX_W-1:0] c_fpix_reg, c_tpix_reg;
    logic [stm_pkg::PIX_W-1:0] d_diff_reg;
    logic [ACC_W-1:0]          acc_reg;

    assign status.pipe_busy = a_vld_reg || b_vld_reg || c_vld_reg || d_vld_reg;
    assign status.scan_last = l_end && k_end;
    assign status.none_left = done_reg
                           || ((10'(cur_row_reg) + 10'(tr)) > 10'(fr))
                           || ((10'(cur_col_reg) + 10'(tc)) > 10'(fc));

    always_ff @(posedge aclk) begin
        if (cmd.wr_frame && frame_wr_ok) frame_mem[wr_faddr] <= in_pixel;
        c_fpix_reg <= frame_mem[b_faddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_tmpl && tmpl_wr_ok) tmpl_mem[wr_taddr] <= in_pixel;
        c_tpix_reg <= tmpl_mem[b_taddr_reg];
    end

    always_comb begin
        k_next = k_reg;
        l_next = l_reg;
        if (cmd.scan_start) begin
            k_next = '0;
            l_next = '0;
        end else if (cmd.scan_step) begin
            if (l_end) begin
                l_next = '0;
                k_next = k_reg + TK_W'(1);
            end else begin
                l_next = l_reg + TL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= cmd.scan_step;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        l_reg       <= l_next;
        a_frow_reg  <= cur_row_reg + PW'(k_reg);
        a_fcol_reg  <= cur_col_reg + PW'(l_reg);
        a_k_reg     <= k_reg;
        a_l_reg     <= l_reg;
        b_faddr_reg <= FA_W'(32'(a_frow_reg) * MAX_FRAME_W + 32'(a_fcol_reg));
        b_taddr_reg <= TA_W'(32'(a_k_reg) * MAX_TMPL_W + 32'(a_l_reg));
        d_diff_reg  <= (c_fpix_reg > c_tpix_reg) ? (c_fpix_reg - c_tpix_reg)
                                                 : (c_tpix_reg - c_fpix_reg);
        if (cmd.scan_start) begin
            acc_reg <= '0;
        end else if (d_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(d_diff_reg);
        end
    end

    // window result and state update
    logic [stm_pkg::SAD_W-1:0] sad_sat;
    logic                      better;
    logic                      col_end, row_end;

    assign sad_sat = (acc_reg > ACC_W'(stm_pkg::SAD_SAT)) ? stm_pkg::SAD_SAT
                                                          : acc_reg[stm_pkg::SAD_W-1:0];
    assign better  = 31'(sad_sat) < best_sad_reg;
    assign col_end = (10'(cur_col_reg) + 10'(tc)) == 10'(fc);
    assign row_end = (10'(cur_row_reg) + 10'(tr)) == 10'(fr);

    always_comb begin
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        done_next     = done_reg;
        best_row_next = best_row_reg;
        best_col_next = best_col_reg;
        best_sad_next = best_sad_reg;
        if (cmd.restart) begin
            cur_row_next  = '0;
            cur_col_next  = '0;
            done_next     = 1'b0;
            best_row_next = stm_pkg::POS_NONE;
            best_col_next = stm_pkg::POS_NONE;
            best_sad_next = stm_pkg::SAD_NONE;
        end else if (cmd.commit) begin
            if (better) begin
                best_sad_next = 31'(sad_sat);
                best_row_next = cur_row_reg;
                best_col_next = cur_col_reg;
            end
            if (col_end) begin
                if (row_end) begin
                    done_next = 1'b1;
                end else begin
                    cur_col_next = '0;
                    cur_row_next = cur_row_reg + PW'(1);
                end
            end else begin
                cur_col_next = cur_col_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            done_reg     <= 1'b0;
            best_row_reg <= stm_pkg::POS_NONE;
            best_col_reg <= stm_pkg::POS_NONE;
            best_sad_reg <= stm_pkg::SAD_NONE;
        end else begin
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            done_reg     <= done_next;
            best_row_reg <= best_row_next;
            best_col_reg <= best_col_next;
            best_sad_reg <= best_sad_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            win_row   <= cur_row_reg[stm_pkg::WIN_W-1:0];
            win_col   <= cur_col_reg[stm_pkg::WIN_W-1:0];
            win_sad   <= sad_sat;
            best_row  <= best_row_next;
            best_col  <= best_col_next;
            best_sad  <= best_sad_next;
            last      <= col_end && row_end;
            none_left <= 1'b0;
        end else if (cmd.load_none) begin
            win_row   <= '0;
            win_col   <= '0;
            win_sad   <= '0;
            best_row  <= best_row_reg;
            best_col  <= best_col_reg;
            best_sad  <= best_sad_reg;
            last      <= 1'b0;
            none_left <= 1'b1;
        end
    end

endmodule

// ===== src/sad_template_match_top.sv =====
// Top level of the SAD template matcher: stream ports, APB register file,
// controller and datapath. Depends on stm_pkg, stm_ctrl and stm_datapath.
//
// Usage:
//   Input stream (s_*): s_tuser carries the op (write frame pixel, write
//   template pixel, evaluate next window, restart); s_tdata carries row, col
//   and pixel. Writes and restart give no result.
//   Each evaluate gives one result on the m_* stream: the window position and
//   score, the running best, m_tlast on the final window and m_tuser set when
//   no window was left.
//   An evaluate scores one pixel pair per cycle, one read per cycle on the
//   frame and template memories; when no window is left the result is loaded
//   without a scan.
//   The block takes one request at a time and is ready again right after the
//   result is loaded into the output register.
//   Sizes are set over APB (frame_cols, frame_rows, tmpl_cols, tmpl_rows at
//   byte addresses 0, 4, 8, 12); the user must do so only while the block is idle, unenforced.
//   Reset: sizes go to 256, 256, 32, 32, the cursor to the first window and the
//   best to none; pixel memories hold garbage until written.
//   A stalled receiver keeps its result in the output register; writes and
//   restart are still taken, a following evaluate waits before its result.
`timescale 1ns / 1ps

module sad_template_match_top #(
    parameter int MAX_FRAME_W = 256,
    parameter int MAX_FRAME_H = 256,
    parameter int MAX_TMPL_W  = 32,
    parameter int MAX_TMPL_H  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [stm_pkg::IN_DATA_W-1:0]       s_tdata,   // row, col, pixel
    input  logic [1:0]                          s_tuser,   // op
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // win_row, win_col, win_sad, best_row, best_col, best_sad, zero pad
    output logic [stm_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,   // none_left
    output logic                                m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [stm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [stm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [stm_pkg::FDIM_W-1:0] frame_cols_reg, frame_rows_reg;
    logic [stm_pkg::TDIM_W-1:0] tmpl_cols_reg, tmpl_rows_reg;
    logic                       cfg_wr;
    logic [1:0]                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cols_reg <= 9'd256;
            frame_rows_reg <= 9'd256;
            tmpl_cols_reg  <= 6'd32;
            tmpl_rows_reg  <= 6'd32;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                stm_pkg::REG_FRAME_COLS: frame_cols_reg <= pwdata[stm_pkg::FDIM_W-1:0];
                stm_pkg::REG_FRAME_ROWS: frame_rows_reg <= pwdata[stm_pkg::FDIM_W-1:0];
                stm_pkg::REG_TMPL_COLS:  tmpl_cols_reg  <= pwdata[stm_pkg::TDIM_W-1:0];
                stm_pkg::REG_TMPL_ROWS:  tmpl_rows_reg  <= pwdata[stm_pkg::TDIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            stm_pkg::REG_FRAME_COLS: prdata = 32'(frame_cols_reg);
            stm_pkg::REG_FRAME_ROWS: prdata = 32'(frame_rows_reg);
            stm_pkg::REG_TMPL_COLS:  prdata = 32'(tmpl_cols_reg);
            stm_pkg::REG_TMPL_ROWS:  prdata = 32'(tmpl_rows_reg);
            default:                 prdata = '0;
        endcase
    end

    stm_pkg::ctrl_cmd_t  cmd;
    stm_pkg::dp_status_t status;

    logic [stm_pkg::WIN_W-1:0]      win_row, win_col;
    logic [stm_pkg::SAD_W-1:0]      win_sad;
    logic [stm_pkg::POS_W-1:0]      best_row, best_col;
    logic [stm_pkg::BEST_SAD_W-1:0] best_sad;
    logic                           last, none_left;

    stm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    stm_datapath #(
        .MAX_FRAME_W (MAX_FRAME_W),
        .MAX_FRAME_H (MAX_FRAME_H),
        .MAX_TMPL_W  (MAX_TMPL_W),
        .MAX_TMPL_H  (MAX_TMPL_H)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .frame_cols (frame_cols_reg),
        .frame_rows (frame_rows_reg),
        .tmpl_cols  (tmpl_cols_reg),
        .tmpl_rows  (tmpl_rows_reg),
        .in_row     (s_tdata[7:0]),
        .in_col     (s_tdata[15:8]),
        .in_pixel   (s_tdata[23:16]),
        .win_row    (win_row),
        .win_col    (win_col),
        .win_sad    (win_sad),
        .best_row   (best_row),
        .best_col   (best_col),
        .best_sad   (best_sad),
        .last       (last),
        .none_left  (none_left)
    );

    assign m_tdata = {5'd0, best_sad, best_col, best_row, win_sad, win_col, win_row};
    assign m_tuser = none_left;
    assign m_tlast = last;

endmodule

// ===== src/stm_checker.sv =====
// Port-level checks for the SAD template matcher, bound to the top level.
// Depends only on the ports of sad_template_match_top.
`timescale 1ns / 1ps

module stm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                   && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_none_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast)
        else $error("no-window result flagged as last");

    a_none_zero_win: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[33:0] == 34'd0)
        else $error("no-window result carries window fields");

    // the running best never exceeds the window just scored
    a_best_le_win: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[82:52] <= {13'd0, m_tdata[33:16]})
        else $error("best score above current window score");

endmodule

bind sad_template_match_top stm_checker u_stm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
